FILE: sv/u8d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int CODE_W       = 21;
    localparam int LEN_W        = 3;

    // queue between front and back; depth must be a power of two
    localparam int QUEUE_DEPTH  = 4;
    localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_buffer;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        logic [LEN_W-1:0]  seq_length;
        logic              last_of_run;
    } out_item_t;

    // up to two results per input byte, written in order
    typedef struct packed {
        logic [1:0] count;
        out_item_t  first;
        out_item_t  second;
    } push_t;

    typedef struct packed {
        logic [QUEUE_CNT_W-1:0] count;
    } queue_status_t;

endpackage

`default_nettype wire

FILE: sv/utf8_stream_decoder.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  signals                              item
// byte     byte_valid / byte_ready / byte_item  in_item_t  (byte_in, end_of_buffer)
// char     char_valid / char_ready / char_item  out_item_t (code_point, seq_length,
//                                                           last_of_run)
//
// One byte per cycle is accepted while byte_ready is high; a result passes
// through a queue slot, then the output register. A byte that drops a pending
// sequence and yields a result of its own gives two results; the 4-entry
// queue absorbs that. byte_ready is low only when fewer than two queue slots
// are free. Reset (rst_n, async) clears the sequence state, queue and output.

module utf8_stream_decoder
    import u8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     byte_valid,
    output logic          byte_ready,
    input  wire in_item_t byte_item,
    output logic          char_valid,
    input  wire logic     char_ready,
    output out_item_t     char_item
);

    logic          accept;
    push_t         push;
    logic          pop;
    logic          not_empty;
    out_item_t     head;
    queue_status_t q_status;

    assign accept = byte_valid && byte_ready;

    u8d_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .push   (push)
    );

    u8d_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (pop),
        .room      (byte_ready),
        .not_empty (not_empty),
        .head      (head),
        .status    (q_status)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .not_empty  (not_empty),
        .head       (head),
        .pop        (pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count over depth");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push.count != 2'd0 |-> q_status.count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2))
        else $error("push into a queue without room");

    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.count != '0 && (!char_valid || char_ready)) |=> char_valid)
        else $error("queued result not moved to output");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_item.seq_length == '0) |-> char_item.code_point == '0)
        else $error("error result with nonzero code point");

    a_ascii_range: assert property (@(posedge clk) disable iff (!rst_n)
        (char_valid && char_item.seq_length == LEN_W'(1))
            |-> char_item.code_point <= CODE_W'(8'h7F))
        else $error("one-byte result above 0x7F");

endmodule

`default_nettype wire

FILE: sv/u8d_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     accept,
    input  wire in_item_t item,
    output push_t         push
);

    typedef enum logic [1:0] {
        LEAD_ASCII,
        LEAD_MULTI,
        LEAD_BAD
    } lead_kind_t;

    logic [CODE_W-1:0] acc_reg, acc_next;
    logic [1:0]        left_reg, left_next;
    logic [LEN_W-1:0]  tot_reg, tot_next;

    lead_kind_t        lead_kind;
    logic [4:0]        lead_payload;
    logic [1:0]        lead_more;
    logic              lead_emits;
    out_item_t         lead_res;
    logic [CODE_W-1:0] acc_shift;
    logic [1:0]        left_dec;
    push_t             push_raw;

    always_comb
    begin
        lead_kind    = LEAD_BAD;
        lead_payload = '0;
        lead_more    = '0;
        unique case (item.byte_in) inside
            8'b0???????:
            begin
                lead_kind = LEAD_ASCII;
            end
            8'b110?????:
            begin
                lead_kind    = LEAD_MULTI;
                lead_payload = item.byte_in[4:0];
                lead_more    = 2'd1;
            end
            8'b1110????:
            begin
                lead_kind    = LEAD_MULTI;
                lead_payload = {1'b0, item.byte_in[3:0]};
                lead_more    = 2'd2;
            end
            8'b11110???:
            begin
                lead_kind    = LEAD_MULTI;
                lead_payload = {2'b00, item.byte_in[2:0]};
                lead_more    = 2'd3;
            end
            default:
            begin
                lead_kind = LEAD_BAD;
            end
        endcase
    end

    // a multi-byte lead only stays silent when more bytes can follow
    assign lead_emits = !(lead_kind == LEAD_MULTI && !item.end_of_buffer);

    always_comb
    begin
        lead_res             = '0;
        lead_res.last_of_run = 1'b1;
        if (lead_kind == LEAD_ASCII)
        begin
            lead_res.code_point = {{(CODE_W-8){1'b0}}, item.byte_in};
            lead_res.seq_length = LEN_W'(1);
        end
    end

    assign acc_shift = {acc_reg[CODE_W-7:0], item.byte_in[5:0]};
    assign left_dec  = left_reg - 2'd1;

    always_comb
    begin
        acc_next  = acc_reg;
        left_next = left_reg;
        tot_next  = tot_reg;
        push_raw  = '0;

        if (left_reg == 2'd0 || item.byte_in[7:6] != 2'b10)
        begin
            // byte examined as a lead, possibly after dropping a pending sequence
            if (left_reg == 2'd0)
            begin
                push_raw.count = lead_emits ? 2'd1 : 2'd0;
                push_raw.first = lead_res;
            end
            else
            begin
                push_raw.count              = lead_emits ? 2'd2 : 2'd1;
                push_raw.first              = '0;
                push_raw.first.last_of_run  = !lead_emits;
                push_raw.second             = lead_res;
            end
            if (lead_emits)
            begin
                acc_next  = '0;
                left_next = '0;
                tot_next  = '0;
            end
            else
            begin
                acc_next  = {{(CODE_W-5){1'b0}}, lead_payload};
                left_next = lead_more;
                tot_next  = {1'b0, lead_more} + LEN_W'(1);
            end
        end
        else if (left_dec == 2'd0)
        begin
            push_raw.count                   = 2'd1;
            push_raw.first.code_point        = acc_shift;
            push_raw.first.seq_length        = tot_reg;
            push_raw.first.last_of_run       = 1'b1;
            acc_next  = '0;
            left_next = '0;
            tot_next  = '0;
        end
        else if (item.end_of_buffer)
        begin
            push_raw.count             = 2'd1;
            push_raw.first.last_of_run = 1'b1;
            acc_next  = '0;
            left_next = '0;
            tot_next  = '0;
        end
        else
        begin
            acc_next  = acc_shift;
            left_next = left_dec;
        end
    end

    always_comb
    begin
        push = push_raw;
        if (!accept)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            left_reg <= '0;
            tot_reg  <= '0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
            tot_reg  <= tot_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u8d_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue
    import u8d_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire push_t   push,
    input  wire logic    pop,
    output logic         room,
    output logic         not_empty,
    output out_item_t    head,
    output queue_status_t status
);

    out_item_t              slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;
    logic [QUEUE_PTR_W-1:0] wr_ptr_inc;

    // room for the worst case of two results from one byte
    assign room         = count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH - 2);
    assign not_empty    = count_reg != '0;
    assign head         = slot_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign wr_ptr_inc   = wr_ptr_reg + QUEUE_PTR_W'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + QUEUE_PTR_W'(pop);
        count_next  = count_reg + QUEUE_CNT_W'(push.count) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[wr_ptr_inc] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u8d_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      not_empty,
    input  wire out_item_t head,
    output logic           pop,
    output logic           char_valid,
    input  wire logic      char_ready,
    output out_item_t      char_item
);

    logic      valid_reg, valid_next;
    out_item_t item_reg;

    assign pop        = not_empty && (!valid_reg || char_ready);
    assign valid_next = pop || (valid_reg && !char_ready);
    assign char_valid = valid_reg;
    assign char_item  = item_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: tb/utf8_stream_decoder_tb.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
    import u8d_pkg::*;

    localparam logic [LEN_W-1:0] BAD_LEN   = '0;   // seq_length of an error result
    localparam int               LONG_HOLD = 80;   // receiver hold-off, cycles
    localparam int               TAIL_CYC  = 20;
    localparam int               N_BYTES   = 1450;

    class char_scoreboard;
        out_item_t         expected_chars[$];
        out_item_t         byte_run[$];
        logic [CODE_W-1:0] acc;
        logic [1:0]        left;
        logic [LEN_W-1:0]  total;
        int                errors;

        function new();
            errors = 0;
            drop_seq();
        endfunction

        function void drop_seq();
            acc   = '0;
            left  = '0;
            total = '0;
        endfunction

        function void add_char(logic [CODE_W-1:0] cp, logic [LEN_W-1:0] len);
            out_item_t c;
            c.code_point  = cp;
            c.seq_length  = len;
            c.last_of_run = 1'b0;
            byte_run.push_back(c);
        endfunction

        function void take_lead(logic [7:0] b, bit eob);
            logic [CODE_W-1:0] payload;
            logic [1:0]        more;
            bit                bad;
            bad     = 1'b0;
            payload = '0;
            more    = '0;
            casez (b)
                8'b0???????:
                begin
                    add_char(CODE_W'(b), LEN_W'(1));
                    return;
                end
                8'b110?????:
                begin
                    payload = CODE_W'(b[4:0]);
                    more    = 2'd1;
                end
                8'b1110????:
                begin
                    payload = CODE_W'(b[3:0]);
                    more    = 2'd2;
                end
                8'b11110???:
                begin
                    payload = CODE_W'(b[2:0]);
                    more    = 2'd3;
                end
                default:
                begin
                    bad = 1'b1;
                end
            endcase
            if (bad)
            begin
                add_char('0, BAD_LEN);
            end
            else if (eob)
            begin
                drop_seq();
                add_char('0, BAD_LEN);
            end
            else
            begin
                acc   = payload;
                left  = more;
                total = LEN_W'(more) + LEN_W'(1);
            end
        endfunction

        // predicts the chars caused by one accepted byte
        function void note_byte(in_item_t it);
            logic [7:0] b;
            bit         eob;
            b   = it.byte_in;
            eob = it.end_of_buffer;
            byte_run.delete();
            if (left == 0)
            begin
                take_lead(b, eob);
            end
            else if (b[7:6] == 2'b10)
            begin
                acc  = {acc[CODE_W-7:0], b[5:0]};
                left = left - 2'd1;
                if (left == 0)
                begin
                    add_char(acc, total);
                    drop_seq();
                end
                else if (eob)
                begin
                    add_char('0, BAD_LEN);
                    drop_seq();
                end
            end
            else
            begin
                // pending sequence broken: error, then the byte is a lead again
                add_char('0, BAD_LEN);
                drop_seq();
                take_lead(b, eob);
            end
            if (byte_run.size() > 0)
                byte_run[byte_run.size()-1].last_of_run = 1'b1;
            foreach (byte_run[i])
                expected_chars.push_back(byte_run[i]);
        endfunction

        function void check_char(out_item_t act);
            out_item_t exp_c;
            if (expected_chars.size() == 0)
            begin
                $error("unexpected char: code_point %h seq_length %0d last_of_run %0b",
                       act.code_point, act.seq_length, act.last_of_run);
                errors++;
                return;
            end
            exp_c = expected_chars.pop_front();
            if (act.code_point !== exp_c.code_point)
            begin
                $error("code_point: expected %h, actual %h", exp_c.code_point, act.code_point);
                errors++;
            end
            if (act.seq_length !== exp_c.seq_length)
            begin
                $error("seq_length: expected %0d, actual %0d",
                       exp_c.seq_length, act.seq_length);
                errors++;
            end
            if (act.last_of_run !== exp_c.last_of_run)
            begin
                $error("last_of_run: expected %0b, actual %0b",
                       exp_c.last_of_run, act.last_of_run);
                errors++;
            end
        endfunction

        function int pending();
            return expected_chars.size();
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_ready;
    in_item_t  byte_item;
    logic      char_valid;
    logic      char_ready;
    out_item_t char_item;

    char_scoreboard sb = new();

    bit gaps_on       = 1'b1;
    bit long_hold_req = 1'b0;
    int burst_left    = 0;
    int sent_bytes    = 0;

    utf8_stream_decoder u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_item  (byte_item),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_item  (char_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && char_valid && char_ready)
            sb.check_char(char_item);
    end

    // receiver: segments of different stall patterns, plus a long hold on request
    initial
    begin
        int mode;
        int seg;
        int cnt;
        cnt = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(20, 200);
            repeat (seg)
            begin
                @(negedge clk);
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    char_ready <= 1'b0;
                    repeat (LONG_HOLD) @(negedge clk);
                end
                cnt++;
                case (mode)
                    0:       char_ready <= 1'b1;
                    1:       char_ready <= ($urandom_range(0, 3) != 0);
                    2:       char_ready <= 1'($urandom_range(0, 1));
                    default: char_ready <= ((cnt % 7) >= 3);
                endcase
            end
        end
    end

    task automatic send_byte(input in_item_t it);
        int gap;
        gap = 0;
        if (gaps_on)
        begin
            if (burst_left == 0)
            begin
                gap        = $urandom_range(1, 6);
                burst_left = $urandom_range(1, 24);
            end
            else
            begin
                burst_left--;
            end
        end
        @(negedge clk);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        @(posedge clk);
        while (!byte_ready) @(posedge clk);
        sb.note_byte(it);
        sent_bytes++;
    endtask

    task automatic put_byte(input logic [7:0] b, input bit eob);
        in_item_t it;
        it.byte_in       = b;
        it.end_of_buffer = eob;
        send_byte(it);
    endtask

    task automatic drop_valid();
        @(negedge clk);
        byte_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        drop_valid();
        while (sb.pending() != 0) @(posedge clk);
    endtask

    function automatic logic [7:0] lead_byte(input int len);
        logic [7:0] r;
        r = 8'($urandom);
        case (len)
            1:       return {1'b0, r[6:0]};
            2:       return {3'b110, r[4:0]};
            3:       return {4'b1110, r[3:0]};
            default: return {5'b11110, r[2:0]};
        endcase
    endfunction

    // sends the first 'count' bytes of a random 'len'-byte sequence
    task automatic send_seq(input int len, input int count, input bit eob_last);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                put_byte(lead_byte(len), eob_last && (i == count - 1));
            else
                put_byte({2'b10, 6'($urandom)}, eob_last && (i == count - 1));
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3) return 1;
        if (r < 5) return 2;
        if (r < 7) return 3;
        return 4;
    endfunction

    initial
    begin
        int r;
        int len;
        int next_flip;
        rst_n      = 1'b0;
        byte_valid = 1'b0;
        byte_item  = '0;
        char_ready = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed
        put_byte(8'h00, 1'b0);
        put_byte(8'h7F, 1'b1);
        put_byte(8'hC2, 1'b0); put_byte(8'hA9, 1'b0);
        put_byte(8'hEF, 1'b0); put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b0);
        // largest value a four-byte form can carry
        put_byte(8'hF7, 1'b0); put_byte(8'hBF, 1'b0);
        put_byte(8'hBF, 1'b0); put_byte(8'hBF, 1'b1);
        // stray continuation and invalid leads
        put_byte(8'h80, 1'b0); put_byte(8'hFF, 1'b0); put_byte(8'hF8, 1'b1);
        // broken sequence, byte reused as ASCII
        put_byte(8'hC3, 1'b0); put_byte(8'h41, 1'b0);
        // broken sequence, byte reused as a lead that is cut by end of buffer
        put_byte(8'hC3, 1'b0); put_byte(8'hE2, 1'b1);
        // continuation with end of buffer before completion
        put_byte(8'hE2, 1'b0); put_byte(8'h82, 1'b1);
        // broken sequence restarted by a new lead that completes
        put_byte(8'hC3, 1'b0); put_byte(8'hC3, 1'b0); put_byte(8'hA9, 1'b0);
        wait_drained();

        next_flip = sent_bytes + 200;
        while (sent_bytes < N_BYTES)
        begin
            if (sent_bytes >= next_flip)
            begin
                gaps_on   = !gaps_on;
                next_flip = sent_bytes + $urandom_range(100, 300);
            end
            if (sent_bytes >= 500 && sent_bytes < 520)
            begin
                // receiver holds off while bytes keep coming
                wait_drained();
                long_hold_req = 1'b1;
                gaps_on       = 1'b0;
                repeat (12) send_seq(pick_len(), pick_len(), 1'b0);
                gaps_on = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (r < 70)
            begin
                len = pick_len();
                send_seq(len, len, $urandom_range(0, 15) == 0);
            end
            else if (r < 80)
            begin
                len = $urandom_range(2, 4);
                send_seq(len, $urandom_range(1, len - 1), 1'b1);
            end
            else if (r < 90)
            begin
                len = $urandom_range(2, 4);
                send_seq(len, $urandom_range(1, len - 1), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    put_byte(8'($urandom), $urandom_range(0, 7) == 0);
            end
        end

        wait_drained();
        repeat (TAIL_CYC) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/u8d_pkg.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_stream_decoder.sv
tb/utf8_stream_decoder_tb.sv
